FILE: src/dtc_pkg.sv
package dtc_pkg;

  localparam int unsigned Entries    = 32;
  localparam int unsigned NameBytes  = 128;
  localparam int unsigned NameWords  = (NameBytes + 7) / 8;
  localparam int unsigned SlotW      = $clog2(Entries);
  localparam int unsigned WordW      = $clog2(NameWords);
  localparam int unsigned LenW       = $clog2(NameBytes);
  localparam int unsigned NameAddrW  = SlotW + WordW;

  localparam logic [31:0] Forever    = 32'hFFFF_FFFF;
  localparam logic [63:0] LocalWord0 = 64'h736F_686C_6163_6F6C;
  localparam logic [7:0]  LocalByte8 = 8'h74;
  localparam logic [7:0]  TypeA      = 8'd1;
  localparam logic [7:0]  TypeAaaa   = 8'd28;
  localparam logic [7:0]  LocalLen   = 8'd9;

  typedef enum logic [1:0] {
    OpChunk = 2'd0,
    OpPut   = 2'd1,
    OpGet   = 2'd2,
    OpTick  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StPreload,
    StScanRd,
    StScanMeta,
    StNameRd,
    StNameCmp,
    StPutWrite,
    StNameWr,
    StTickRd,
    StTickWr,
    StDone
  } state_e;

  // Byte-enable mask of word w for a name of len bytes
  function automatic logic [63:0] byte_mask(logic [7:0] len, logic [WordW-1:0] w);
    logic [11:0] lo;
    logic [11:0] l;
    logic [63:0] m;
    lo = {{(9-WordW){1'b0}}, w, 3'b000};
    l  = {4'd0, len};
    m  = '0;
    if (l >= lo + 12'd8) begin
      m = '1;
    end else if (l > lo) begin
      for (int b = 0; b < 8; b++) begin
        if (12'(b) < l - lo) m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: src/dns_ttl_cache.sv
// Fully associative 32-entry TTL cache, one transaction at a time.
// Name chunk: written into the key buffer on acceptance. Put and get: a metadata scan
// reads each slot in turn and compares name words on a candidate slot; a get then
// raises its result, and a put that fills a new slot writes all 16 name words.
// Tick: reads and ages each slot in turn. Reset: asynchronous, active low; slots 0 and 1
// are loaded with localhost after reset, while no transaction is accepted.
module dns_ttl_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  chunk_index_i,
  input  logic [63:0] chunk_data_i,
  input  logic [7:0]  key_length_i,
  input  logic [7:0]  record_type_i,
  input  logic [63:0] address_high_i,
  input  logic [63:0] address_low_i,
  input  logic [31:0] lifetime_ms_i,
  input  logic [31:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  import dtc_pkg::*;

  typedef struct packed {
    logic [7:0]   rtype;
    logic [LenW-1:0] len;
    logic [31:0]  life;
  } meta_t;

  // Valid bits in flip-flops; metadata, address and names in memories
  logic [Entries-1:0] valid_q, valid_d;
  meta_t       meta_mem [Entries];
  logic [127:0] addr_mem [Entries];
  logic [63:0] name_mem [Entries*NameWords];
  logic [63:0] key_mem  [NameWords];

  meta_t        meta_rd_q;
  logic [127:0] addr_rd_q;
  logic [63:0]  name_rd_q, key_rd_q;

  state_e state_q, state_d;
  logic [1:0]       op_q;
  logic [7:0]       len_q, type_q;
  logic [127:0]     addr_in_q;
  logic [31:0]      life_q, ms_q;
  logic [SlotW:0]   slot_q, slot_d;
  logic [WordW:0]   word_q, word_d;
  logic             hasfree_q, hasfree_d;
  logic [SlotW-1:0] free_q, free_d;
  logic             islocal_q, islocal_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [127:0]     res_q, res_d;

  logic             meta_we, addr_we, name_we, key_we;
  logic [SlotW-1:0] meta_wa;
  meta_t            meta_wd;
  logic [127:0]     addr_wd;
  logic [NameAddrW-1:0] name_wa, name_ra;
  logic [63:0]      name_wd;
  logic [SlotW-1:0] meta_ra;
  logic [WordW-1:0] key_ra;

  logic accept;
  logic len_ok;
  logic [WordW:0] nwords;
  logic [SlotW-1:0] cur;
  logic [WordW-1:0] curw;
  logic [63:0] cmask;

  assign cur    = slot_q[SlotW-1:0];
  assign curw   = word_q[WordW-1:0];
  assign len_ok = (len_q != 8'd0) && ({1'b0, len_q} < 9'(NameBytes));
  assign nwords = (WordW+1)'((len_q + 8'd7) >> 3);
  assign cmask  = byte_mask(len_q, curw);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (addr_we) addr_mem[meta_wa] <= addr_wd;
    if (name_we) name_mem[name_wa] <= name_wd;
    if (key_we)  key_mem[chunk_index_i[WordW-1:0]] <= chunk_data_i;
    meta_rd_q <= meta_mem[meta_ra];
    addr_rd_q <= addr_mem[meta_ra];
    name_rd_q <= name_mem[name_ra];
    key_rd_q  <= key_mem[key_ra];
  end

  assign key_we = accept && (op_e'(opcode_i) == OpChunk) &&
                  ({1'b0, chunk_index_i} < 5'(NameWords));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StPreload;
      valid_q     <= '0;
      slot_q      <= '0;
      word_q      <= '0;
      hasfree_q   <= 1'b0;
      free_q      <= '0;
      islocal_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      slot_q      <= slot_d;
      word_q      <= word_d;
      hasfree_q   <= hasfree_d;
      free_q      <= free_d;
      islocal_q   <= islocal_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture transaction payload and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= opcode_i;
      len_q     <= key_length_i;
      type_q    <= record_type_i;
      addr_in_q <= {address_high_i, address_low_i};
      life_q    <= lifetime_ms_i;
      ms_q      <= elapsed_ms_i;
    end
    found_q <= found_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d = state_q; valid_d = valid_q; slot_d = slot_q; word_d = word_q;
    hasfree_d = hasfree_q; free_d = free_q; islocal_d = islocal_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d = found_q; res_d = res_q;
    meta_we = 1'b0; addr_we = 1'b0; name_we = 1'b0;
    meta_wa = cur; meta_wd = '0; addr_wd = '0;
    name_wa = {cur, curw}; name_wd = '0;
    meta_ra = cur; name_ra = {cur, curw}; key_ra = curw;
    unique case (state_q)
      // Load localhost into slots 0 and 1
      StPreload: begin
        meta_we = 1'b1; addr_we = 1'b1; name_we = 1'b1;
        meta_wa = cur;
        meta_wd = '{rtype: cur[0] ? TypeAaaa : TypeA,
                    len: LenW'(LocalLen), life: Forever};
        addr_wd = cur[0] ? 128'd1 : {64'h7F00_0001_0000_0000, 64'd0};
        name_wa = {cur, curw};
        name_wd = curw[0] ? {56'd0, LocalByte8} : LocalWord0;
        if (curw[0]) begin
          valid_d[cur] = 1'b1;
          word_d = '0;
          if (cur[0]) begin
            slot_d = '0; state_d = StIdle;
          end else slot_d = slot_q + 1'b1;
        end else word_d = word_q + 1'b1;
      end
      StIdle: begin
        slot_d = '0; word_d = '0; hasfree_d = 1'b0; islocal_d = 1'b0;
        if (accept) begin
          unique case (op_e'(opcode_i))
            OpChunk: state_d = StIdle;
            OpTick:  state_d = StTickRd;
            default: state_d = StScanRd;
          endcase
        end
      end
      StScanRd: begin
        if (!len_ok || (op_q == OpPut && life_q == 32'd0)) begin
          found_d = 1'b0; res_d = '0;
          state_d = (op_q == OpGet) ? StDone : StIdle;
        end else if (slot_q == (SlotW+1)'(Entries)) begin
          found_d = 1'b0; res_d = '0;
          state_d = (op_q == OpGet) ? StDone : StPutWrite;
        end else begin
          meta_ra = cur; state_d = StScanMeta;
        end
      end
      StScanMeta: begin
        if (!valid_q[cur]) begin
          if (!hasfree_q) begin
            hasfree_d = 1'b1; free_d = cur;
          end
          slot_d = slot_q + 1'b1; state_d = StScanRd;
        end else if (meta_rd_q.rtype != type_q ||
                     {1'b0, meta_rd_q.len} != len_q ||
                     (op_q == OpGet && meta_rd_q.life == 32'd0)) begin
          slot_d = slot_q + 1'b1; state_d = StScanRd;
        end else begin
          word_d = '0; state_d = StNameRd;
        end
      end
      StNameRd: begin
        name_ra = {cur, curw}; key_ra = curw; state_d = StNameCmp;
      end
      // Compare one name word; also note whether the key is localhost
      StNameCmp: begin
        if (curw == '0) islocal_d = (key_rd_q == LocalWord0);
        else if (curw == WordW'(1)) islocal_d = islocal_q && (key_rd_q[7:0] == LocalByte8);
        if ((name_rd_q & cmask) != (key_rd_q & cmask)) begin
          word_d = '0; slot_d = slot_q + 1'b1; state_d = StScanRd;
        end else if (word_q + 1'b1 >= nwords) begin
          if (op_q == OpGet) begin
            found_d = 1'b1; res_d = addr_rd_q; state_d = StDone;
          end else begin
            meta_we = 1'b1; addr_we = 1'b1; meta_wa = cur;
            meta_wd = '{rtype: type_q, len: LenW'(len_q),
                        life: ((len_q == LocalLen) && (type_q == TypeA ||
                              type_q == TypeAaaa) && (curw == WordW'(1)) &&
                              islocal_d) ? Forever : life_q};
            addr_wd = addr_in_q;
            state_d = StIdle;
          end
        end else begin
          word_d = word_q + 1'b1; state_d = StNameRd;
        end
      end
      // Fill a new slot: name words one per cycle, metadata with the last name word
      StPutWrite: begin
        slot_d = {1'b0, hasfree_q ? free_q : SlotW'(0)};
        word_d = '0; key_ra = '0; state_d = StNameWr;
      end
      StNameWr: begin
        key_ra = WordW'(word_q + 1'b1);
        name_we = 1'b1; name_wa = {cur, curw};
        name_wd = key_rd_q & cmask;
        if (curw == '0) islocal_d = (key_rd_q == LocalWord0);
        else if (curw == WordW'(1)) islocal_d = islocal_q && (key_rd_q[7:0] == LocalByte8);
        if (word_q == (WordW+1)'(NameWords - 1)) begin
          meta_we = 1'b1; addr_we = 1'b1; meta_wa = cur;
          meta_wd = '{rtype: type_q, len: LenW'(len_q),
                      life: ((len_q == LocalLen) && (type_q == TypeA ||
                            type_q == TypeAaaa) && islocal_d) ? Forever : life_q};
          addr_wd = addr_in_q;
          valid_d[cur] = 1'b1;
          state_d = StIdle;
        end else word_d = word_q + 1'b1;
      end
      StTickRd: begin
        if (slot_q == (SlotW+1)'(Entries)) state_d = StIdle;
        else begin
          meta_ra = cur; state_d = StTickWr;
        end
      end
      // Age one slot; expired slots read back as empty metadata
      StTickWr: begin
        if (valid_q[cur]) begin
          if (meta_rd_q.life == 32'd0) valid_d[cur] = 1'b0;
          else if (meta_rd_q.life != Forever) begin
            meta_we = 1'b1; meta_wa = cur;
            if (meta_rd_q.life <= ms_q) begin
              valid_d[cur] = 1'b0; meta_wd = '0;
            end else begin
              meta_wd = meta_rd_q; meta_wd.life = meta_rd_q.life - ms_q;
            end
          end
        end
        slot_d = slot_q + 1'b1; state_d = StTickRd;
      end
      StDone: begin
        out_valid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("accept while busy");
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid_q) else $error("lost result");
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (res_q == '0)) else $error("nonzero miss");
`endif

endmodule

FILE: tb/tb.sv
module tb;
  import dtc_pkg::*;

  typedef struct {
    op_e         op;
    logic [3:0]  idx;
    logic [63:0] data;
    logic [7:0]  len;
    logic [7:0]  rtype;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] life;
    logic [31:0] ms;
  } cmd_t;

  typedef struct {
    logic        found;
    logic [63:0] hi;
    logic [63:0] lo;
  } answer_t;

  typedef struct {
    cmd_t    c;
    bit      typed;
    answer_t a;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [3:0]  chunk_index;
  logic [63:0] chunk_data;
  logic [7:0]  key_length;
  logic [7:0]  record_type;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [31:0] lifetime_ms;
  logic [31:0] elapsed_ms;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic [63:0] result_high;
  logic [63:0] result_low;

  dns_ttl_cache u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .chunk_index_i  (chunk_index),
    .chunk_data_i   (chunk_data),
    .key_length_i   (key_length),
    .record_type_i  (record_type),
    .address_high_i (address_high),
    .address_low_i  (address_low),
    .lifetime_ms_i  (lifetime_ms),
    .elapsed_ms_i   (elapsed_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .result_high_o  (result_high),
    .result_low_o   (result_low)
  );

  // Shadow copy of the cache contents
  logic        sh_valid [Entries];
  logic [7:0]  sh_type  [Entries];
  logic [7:0]  sh_len   [Entries];
  logic [63:0] sh_name  [Entries][NameWords];
  logic [31:0] sh_life  [Entries];
  logic [63:0] sh_hi    [Entries];
  logic [63:0] sh_lo    [Entries];
  logic [63:0] sh_key   [NameWords];

  answer_t lookups_pending[$];
  int      errors;
  int      hits;
  int      misses;
  int      puts;
  int      ticks;
  bit      calm;
  int      stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] word_mask(logic [7:0] len, int w);
    int lo;
    lo = 8 * w;
    if (int'(len) >= lo + 8) return '1;
    if (int'(len) <= lo) return '0;
    return (64'd1 << (8 * (int'(len) - lo))) - 64'd1;
  endfunction

  function automatic bit key_equals(int s, logic [7:0] len);
    for (int w = 0; w < NameWords; w++) begin
      if ((sh_name[s][w] & word_mask(len, w)) != (sh_key[w] & word_mask(len, w))) return 0;
    end
    return 1;
  endfunction

  function automatic void wipe_slot(int s);
    sh_valid[s] = 1'b0;
    sh_type[s]  = '0;
    sh_len[s]   = '0;
    for (int w = 0; w < NameWords; w++) sh_name[s][w] = '0;
    sh_life[s]  = '0;
    sh_hi[s]    = '0;
    sh_lo[s]    = '0;
  endfunction

  function automatic void cache_reset();
    for (int s = 0; s < Entries; s++) wipe_slot(s);
    for (int w = 0; w < NameWords; w++) sh_key[w] = '0;
    for (int s = 0; s < 2; s++) begin
      sh_valid[s]   = 1'b1;
      sh_len[s]     = LocalLen;
      sh_name[s][0] = LocalWord0;
      sh_name[s][1] = {56'd0, LocalByte8};
      sh_life[s]    = Forever;
    end
    sh_type[0] = TypeA;
    sh_hi[0]   = 64'h7F00_0001_0000_0000;
    sh_type[1] = TypeAaaa;
    sh_lo[1]   = 64'd1;
  endfunction

  // Apply one transaction to the shadow; return 1 with the answer for a get
  function automatic bit cache_apply(cmd_t c, output answer_t a);
    int          free_slot;
    int          s;
    logic [31:0] life;
    a = '{1'b0, 64'd0, 64'd0};
    case (c.op)
      OpChunk: begin
        sh_key[c.idx] = c.data;
        return 0;
      end
      OpPut: begin
        if (c.len == 0 || c.len >= NameBytes || c.life == 0) return 0;
        life = c.life;
        if (c.len == LocalLen && (c.rtype == TypeA || c.rtype == TypeAaaa) &&
            sh_key[0] == LocalWord0 && sh_key[1][7:0] == LocalByte8) life = Forever;
        free_slot = -1;
        for (s = 0; s < Entries; s++) begin
          if (!sh_valid[s]) begin
            if (free_slot < 0) free_slot = s;
          end else if (sh_type[s] == c.rtype && sh_len[s] == c.len && key_equals(s, c.len)) begin
            sh_hi[s]   = c.hi;
            sh_lo[s]   = c.lo;
            sh_life[s] = life;
            return 0;
          end
        end
        s = free_slot < 0 ? 0 : free_slot;
        sh_valid[s] = 1'b1;
        sh_type[s]  = c.rtype;
        sh_len[s]   = c.len;
        for (int w = 0; w < NameWords; w++) sh_name[s][w] = sh_key[w] & word_mask(c.len, w);
        sh_life[s]  = life;
        sh_hi[s]    = c.hi;
        sh_lo[s]    = c.lo;
        return 0;
      end
      OpTick: begin
        for (s = 0; s < Entries; s++) begin
          if (!sh_valid[s]) continue;
          if (sh_life[s] == 0) sh_valid[s] = 1'b0;
          else if (sh_life[s] == Forever) continue;
          else if (sh_life[s] <= c.ms) wipe_slot(s);
          else sh_life[s] -= c.ms;
        end
        return 0;
      end
      default: begin
        if (c.len == 0 || c.len >= NameBytes) return 1;
        for (s = 0; s < Entries; s++) begin
          if (sh_valid[s] && sh_type[s] == c.rtype && sh_life[s] != 0 &&
              sh_len[s] == c.len && key_equals(s, c.len)) begin
            a = '{1'b1, sh_hi[s], sh_lo[s]};
            return 1;
          end
        end
        return 1;
      end
    endcase
  endfunction

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send(cmd_t c, bit typed, answer_t typed_ans);
    int      gap;
    answer_t a;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode       <= c.op;
    chunk_index  <= c.idx;
    chunk_data   <= c.data;
    key_length   <= c.len;
    record_type  <= c.rtype;
    address_high <= c.hi;
    address_low  <= c.lo;
    lifetime_ms  <= c.life;
    elapsed_ms   <= c.ms;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (cache_apply(c, a)) lookups_pending.push_back(typed ? typed_ans : a);
    if (c.op == OpPut) puts++;
    if (c.op == OpTick) ticks++;
  endtask

  // Check each answer against the oldest pending lookup, then draw a stall
  always @(posedge clk) begin
    answer_t e;
    int      n;
    if (rst_n && out_valid && !out_stall) begin
      if (lookups_pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected answer found=%0d %h_%h", found, result_high,
                                   result_low);
      end else begin
        e = lookups_pending.pop_front();
        if (e.found) hits++;
        else misses++;
        if (found !== e.found || result_high !== e.hi || result_low !== e.lo) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp found=%0d %h_%h got found=%0d %h_%h",
                     e.found, e.hi, e.lo, found, result_high, result_low);
        end
      end
      n = calm ? 0 : $urandom_range(0, 18);
      stall_left = n > 0 ? n - 1 : 0;
      out_stall <= (n > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [63:0] pick_word(int w);
    case ($urandom_range(0, 5))
      0:       return w == 0 ? LocalWord0 : {56'd0, LocalByte8};
      1:       return 64'hA5A5_0F0F_3C3C_9696 ^ 64'(w);
      2:       return 64'h0123_4567_89AB_CDEF + 64'(w);
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   k;
    c.idx   = 4'($urandom_range(0, 15));
    c.data  = {$urandom, $urandom};
    c.hi    = {$urandom, $urandom};
    c.lo    = {$urandom, $urandom};
    c.ms    = $urandom;
    c.life  = $urandom;
    k = $urandom_range(0, 9);
    if (k < 8) c.len = 8'($urandom_range(1, 24));
    else if (k == 8) c.len = 8'($urandom_range(25, 127));
    else c.len = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(128, 255));
    case ($urandom_range(0, 4))
      0:       c.rtype = 8'($urandom);
      1:       c.rtype = 8'd5;
      2:       c.rtype = TypeAaaa;
      default: c.rtype = TypeA;
    endcase
    k = $urandom_range(0, 19);
    if (k < 7) begin
      c.op = OpChunk;
      if ($urandom_range(0, 3) != 0) c.idx = 4'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) c.data = pick_word(int'(c.idx));
    end else if (k < 12) c.op = OpPut;
    else if (k < 17) c.op = OpGet;
    else c.op = OpTick;
    case ($urandom_range(0, 9))
      0:       c.life = Forever;
      1:       c.life = '0;
      2:       ;
      default: c.life = $urandom_range(1, 300);
    endcase
    case ($urandom_range(0, 19))
      0:       c.ms = Forever;
      1:       ;
      default: c.ms = $urandom_range(0, 40);
    endcase
    return c;
  endfunction

  row_t    rows[$];
  cmd_t    c;
  answer_t none;

  initial begin
    errors = 0; hits = 0; misses = 0; puts = 0; ticks = 0;
    calm = 0; stall_left = 0;
    in_valid = 0; out_stall = 0;
    opcode = OpChunk; chunk_index = 0; chunk_data = 0; key_length = 0;
    record_type = 0; address_high = 0; address_low = 0; lifetime_ms = 0; elapsed_ms = 0;
    none = '{1'b0, 64'd0, 64'd0};
    cache_reset();
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole key buffer first, localhost in words 0 and 1
    for (int w = 0; w < NameWords; w++)
      rows.push_back('{'{OpChunk, 4'(w), w == 0 ? LocalWord0 : (w == 1 ? 64'h74 : 64'd0),
                         0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OpGet, 0, 0, 9, TypeA, 0, 0, 0, 0}, 1,
                     '{1'b1, 64'h7F00_0001_0000_0000, 64'd0}});
    rows.push_back('{'{OpGet, 0, 0, 9, TypeAaaa, 0, 0, 0, 0}, 1, '{1'b1, 64'd0, 64'd1}});
    rows.push_back('{'{OpGet, 0, 0, 0, TypeA, 0, 0, 0, 0}, 1, none});
    rows.push_back('{'{OpGet, 0, 0, 255, TypeA, 0, 0, 0, 0}, 1, none});
    rows.push_back('{'{OpPut, 0, 0, 9, TypeA, 64'h1111, 64'h2222, 5, 0}, 0, none});
    rows.push_back('{'{OpTick, 0, 0, 0, 0, 0, 0, 0, Forever}, 0, none});
    rows.push_back('{'{OpGet, 0, 0, 9, TypeA, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OpPut, 0, 0, 9, 8'd7, 64'h3, 64'h4, 0, 0}, 0, none});
    rows.push_back('{'{OpPut, 0, 0, 9, 8'd7, 64'h5, 64'h6, 10, 0}, 0, none});
    rows.push_back('{'{OpGet, 0, 0, 9, 8'd7, 0, 0, 0, 0}, 1, '{1'b1, 64'h5, 64'h6}});
    rows.push_back('{'{OpTick, 0, 0, 0, 0, 0, 0, 0, 10}, 0, none});
    rows.push_back('{'{OpGet, 0, 0, 9, 8'd7, 0, 0, 0, 0}, 1, none});
    rows.push_back('{'{OpChunk, 15, '1, 0, 0, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OpPut, 0, 0, 127, 8'hFF, '1, '1, 32'hFFFF_FFFE, 0}, 0, none});
    rows.push_back('{'{OpGet, 0, 0, 127, 8'hFF, 0, 0, 0, 0}, 0, none});
    rows.push_back('{'{OpPut, 0, 0, 128, TypeA, 1, 1, 1, 0}, 0, none});
    foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].a);

    // Random traffic, with calm stretches and one full drain midway
    for (int i = 0; i < 1750; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == 800) begin
        in_valid <= 1'b0;
        while (lookups_pending.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      c = random_cmd();
      send(c, 0, none);
    end
    in_valid <= 1'b0;

    // Drain and let the last scan finish
    while (lookups_pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (lookups_pending.size() != 0) errors++;
    $display("covered %0d puts, %0d ticks, %0d lookup hits, %0d lookup misses",
             puts, ticks, hits, misses);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dtc_pkg.sv
src/dns_ttl_cache.sv
tb/tb.sv
